// ----- rtl/core/oblivious_oram_stash_core_defines.svh -----
// Assertion macros for the stash core.
// No dependencies; included by the top level, which provides clk_i and rst_ni.
`ifndef OBLIVIOUS_ORAM_STASH_CORE_DEFINES_SVH
`define OBLIVIOUS_ORAM_STASH_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OOS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stash core check failed");

// Next-cycle implication, checked out of reset.
`define OOS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stash core check failed");

`endif

// ----- rtl/core/oos_pkg.sv -----
// Shared types and constants of the stash core.
// No dependencies.
package oos_pkg;

  // Default sizes
  localparam int unsigned STASH_DEPTH_DEF = 64;
  localparam int unsigned DATA_BITS_DEF   = 64;
  localparam int unsigned ID_BITS_DEF     = 32;

  // Fixed field widths
  localparam int unsigned FUNC_BITS      = 2;
  localparam int unsigned BLOCK_ID_BITS  = 32;
  localparam int unsigned LEAF_BITS      = 32;
  localparam int unsigned DATA_IN_BITS   = 64;
  localparam int unsigned CFG_BITS       = 32;
  localparam int unsigned IN_TDATA_BITS  = BLOCK_ID_BITS + LEAF_BITS + DATA_IN_BITS;
  localparam int unsigned IN_TUSER_BITS  = FUNC_BITS + 1;
  localparam int unsigned OUT_TDATA_BITS = 64;
  localparam int unsigned OUT_TUSER_BITS = 3;

  // Request kinds
  typedef enum logic [FUNC_BITS-1:0] {
    FN_READ    = 2'd0,
    FN_WRITE   = 2'd1,
    FN_RELABEL = 2'd2,
    FN_INSERT  = 2'd3
  } oos_func_e;

  // Result status flags, hit in the lowest bit
  typedef struct packed {
    logic overflow;
    logic inserted;
    logic hit;
  } oos_flags_t;

endpackage

// ----- rtl/core/oos_mem.sv -----
// Slot memory: one synchronous RAM of packed slots plus per-slot valid bits.
// Depends on nothing; an invalid slot is reported through rd_vld_o.
module oos_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned EW    = 128,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [EW-1:0] rd_data_o,
  output logic          rd_vld_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [EW-1:0] wr_data_i
);

  logic [EW-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [EW-1:0] rd_data_q;
  logic rd_vld_q;

  // RAM array, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: cleared at reset, set on first write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

// ----- rtl/core/oos_ctrl.sv -----
// Scan sequencer: walks all slots read-modify-write and holds the result register.
// Depends on oos_pkg and oos_mem.
module oos_ctrl #(
  parameter int unsigned STASH_DEPTH = 64,
  parameter int unsigned DATA_BITS   = 64,
  parameter int unsigned ID_BITS     = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ID_BITS-1:0]       dummy_id_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  oos_pkg::oos_func_e       in_func_i,
  input  logic [ID_BITS-1:0]       in_id_i,
  input  logic [oos_pkg::LEAF_BITS-1:0] in_leaf_i,
  input  logic [DATA_BITS-1:0]     in_data_i,
  input  logic                     in_dummy_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DATA_BITS-1:0]     out_data_o,
  output oos_pkg::oos_flags_t      out_flags_o
);
  import oos_pkg::*;

  localparam int unsigned AW = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;
  localparam int unsigned EW = ID_BITS + LEAF_BITS + DATA_BITS;
  localparam logic [AW-1:0] LAST = AW'(STASH_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  oos_func_e func_q, func_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [LEAF_BITS-1:0] leaf_q, leaf_d;
  logic [DATA_BITS-1:0] data_q, data_d;
  logic dmy_q, dmy_d;
  logic [AW-1:0] rd_cnt_q, rd_cnt_d;
  logic rd_act_q, rd_act_d;
  logic [AW-1:0] wb_addr_q, wb_addr_d;
  logic wb_vld_q, wb_vld_d;
  logic hit_q, hit_d;
  logic ins_q, ins_d;
  logic [DATA_BITS-1:0] dout_q, dout_d;
  logic out_vld_q, out_vld_d;
  logic [DATA_BITS-1:0] out_data_q, out_data_d;
  oos_flags_t out_flags_q, out_flags_d;

  logic [EW-1:0] rd_data, wr_data;
  logic rd_vld;
  logic [ID_BITS-1:0] slot_id;
  logic [LEAF_BITS-1:0] slot_leaf, new_leaf;
  logic [DATA_BITS-1:0] slot_data, new_data;
  logic slot_match, slot_free, take;

  oos_mem #(
    .DEPTH(STASH_DEPTH),
    .EW   (EW),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_act_q),
    .rd_addr_i(rd_cnt_q),
    .rd_data_o(rd_data),
    .rd_vld_o (rd_vld),
    .wr_en_i  (wb_vld_q),
    .wr_addr_i(wb_addr_q),
    .wr_data_i(wr_data)
  );

  // Slot seen in write-back stage; a never-written slot holds its reset contents
  always_comb begin
    if (rd_vld) begin
      slot_id   = rd_data[EW-1 -: ID_BITS];
      slot_leaf = rd_data[DATA_BITS+LEAF_BITS-1 -: LEAF_BITS];
      slot_data = rd_data[DATA_BITS-1:0];
    end else begin
      slot_id   = '1;
      slot_leaf = '0;
      slot_data = '0;
    end
  end

  // Slot modify
  assign slot_match = (slot_id == id_q);
  assign slot_free  = (slot_id == dummy_id_i);
  assign take       = (func_q == FN_INSERT) && !dmy_q && !ins_q && slot_free;

  always_comb begin
    new_leaf = slot_leaf;
    new_data = slot_data;
    if (take) begin
      new_leaf = leaf_q;
      new_data = data_q;
    end else if ((func_q != FN_INSERT) && slot_match) begin
      new_leaf = leaf_q;
      if (func_q == FN_WRITE) begin
        new_data = data_q;
      end
    end
  end

  always_comb begin
    if (take) begin
      wr_data = {id_q, new_leaf, new_data};
    end else begin
      wr_data = {slot_id, new_leaf, new_data};
    end
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    id_d        = id_q;
    leaf_d      = leaf_q;
    data_d      = data_q;
    dmy_d       = dmy_q;
    rd_cnt_d    = rd_cnt_q;
    rd_act_d    = rd_act_q;
    wb_addr_d   = rd_cnt_q;
    wb_vld_d    = rd_act_q;
    hit_d       = hit_q;
    ins_d       = ins_q;
    dout_d      = dout_q;
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;
    out_flags_d = out_flags_q;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d  = ST_SCAN;
          func_d   = in_func_i;
          id_d     = in_id_i;
          leaf_d   = in_leaf_i;
          data_d   = in_data_i;
          dmy_d    = in_dummy_i;
          rd_cnt_d = '0;
          rd_act_d = 1'b1;
          hit_d    = 1'b0;
          ins_d    = 1'b0;
          dout_d   = '0;
        end
      end
      ST_SCAN: begin
        if (rd_act_q) begin
          if (rd_cnt_q == LAST) begin
            rd_act_d = 1'b0;
          end else begin
            rd_cnt_d = rd_cnt_q + 1'b1;
          end
        end
        if (wb_vld_q) begin
          if (take) begin
            ins_d = 1'b1;
          end
          if ((func_q != FN_INSERT) && slot_match) begin
            hit_d = 1'b1;
            if (func_q == FN_READ) begin
              dout_d = slot_data;
            end
          end
          // last write-back lands before the next request can read slot zero
          if (wb_addr_q == LAST) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!out_vld_q || out_ready_i) begin
          state_d              = ST_IDLE;
          out_vld_d            = 1'b1;
          out_data_d           = dout_q;
          out_flags_d.hit      = hit_q;
          out_flags_d.inserted = ins_q;
          out_flags_d.overflow = (func_q == FN_INSERT) && !dmy_q && !ins_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= FN_READ;
      id_q        <= '0;
      leaf_q      <= '0;
      data_q      <= '0;
      dmy_q       <= 1'b0;
      rd_cnt_q    <= '0;
      rd_act_q    <= 1'b0;
      wb_addr_q   <= '0;
      wb_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      ins_q       <= 1'b0;
      dout_q      <= '0;
      out_vld_q   <= 1'b0;
      out_data_q  <= '0;
      out_flags_q <= '0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      id_q        <= id_d;
      leaf_q      <= leaf_d;
      data_q      <= data_d;
      dmy_q       <= dmy_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_act_q    <= rd_act_d;
      wb_addr_q   <= wb_addr_d;
      wb_vld_q    <= wb_vld_d;
      hit_q       <= hit_d;
      ins_q       <= ins_d;
      dout_q      <= dout_d;
      out_vld_q   <= out_vld_d;
      out_data_q  <= out_data_d;
      out_flags_q <= out_flags_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_flags_o = out_flags_q;

endmodule

// ----- rtl/core/oblivious_oram_stash_core.sv -----
// Path ORAM stash core top level: stream ports, dummy id register, assertions.
// Depends on oos_pkg, oos_ctrl, oos_mem and oblivious_oram_stash_core_defines.svh.
//
// Usage:
//  - s_axis carries one request: read, write, relabel or insert (func in tuser).
//  - Every request scans all STASH_DEPTH slots of the slot RAM, one slot read and
//    one slot written back per cycle, so the RAM port sets the rate.
//  - One result per request on m_axis; a new request is taken only once the
//    previous one has been scanned and its result moved to the output register.
//  - s_axis_tready is high only while no request is in the scan.
//  - The result sits in an output register; the next request may be accepted
//    and scanned while it waits. If m_axis still stalls at the end of that
//    scan, the core holds the new result and takes no further request.
//  - cfg carries the dummy id; write it only while the core is idle.
//  - Reset: dummy id all ones, all slots read as empty (dummy id, zero leaf,
//    zero data) through per-slot valid bits, so no clearing pass is needed.
//  - Result flags: hit on accesses; inserted or overflow on non-dummy inserts.
`include "oblivious_oram_stash_core_defines.svh"

module oblivious_oram_stash_core #(
  parameter int unsigned STASH_DEPTH = oos_pkg::STASH_DEPTH_DEF,
  parameter int unsigned DATA_BITS   = oos_pkg::DATA_BITS_DEF,
  parameter int unsigned ID_BITS     = oos_pkg::ID_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: block_id[31:0], new_leaf[63:32], data_in[127:64]
  input  logic [oos_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  // tuser: func[1:0], dummy_blk[2]
  input  logic [oos_pkg::IN_TUSER_BITS-1:0]   s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: rd_word[63:0]
  output logic [oos_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  // tuser: hit[0], inserted[1], overflow[2]
  output logic [oos_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser,
  // dummy id write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [oos_pkg::CFG_BITS-1:0]        cfg_data_i
);
  import oos_pkg::*;

  logic [ID_BITS-1:0] dummy_id_q;
  logic [DATA_BITS-1:0] res_data;
  oos_flags_t res_flags;
  oos_func_e req_func;

  // Dummy id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dummy_id_q <= '1;
    end else if (cfg_valid_i) begin
      dummy_id_q <= ID_BITS'(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;

  // Request field unpacking
  assign req_func = oos_func_e'(s_axis_tuser[FUNC_BITS-1:0]);

  oos_ctrl #(
    .STASH_DEPTH(STASH_DEPTH),
    .DATA_BITS  (DATA_BITS),
    .ID_BITS    (ID_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dummy_id_i (dummy_id_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (req_func),
    .in_id_i    (s_axis_tdata[ID_BITS-1:0]),
    .in_leaf_i  (s_axis_tdata[BLOCK_ID_BITS +: LEAF_BITS]),
    .in_data_i  (s_axis_tdata[BLOCK_ID_BITS+LEAF_BITS +: DATA_BITS]),
    .in_dummy_i (s_axis_tuser[FUNC_BITS]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (res_data),
    .out_flags_o(res_flags)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'(res_data);
  assign m_axis_tuser = res_flags;

  // Accepted request makes the core busy for the scan
  `OOS_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // Access and insert flags never mix, inserted and overflow exclude each other
  `OOS_ASSERT_NOW(a_flags_excl, m_axis_tvalid,
                  !(res_flags.hit && (res_flags.inserted || res_flags.overflow)) &&
                  !(res_flags.inserted && res_flags.overflow))
  // Read data is only returned on a hit
  `OOS_ASSERT_NOW(a_data_needs_hit, m_axis_tvalid && (res_data != '0), res_flags.hit)

endmodule

// ----- verif/tb_top.sv -----
// Testbench for oblivious_oram_stash_core: directed and random stash requests,
// checked against a scoreboard that mirrors every slot of the stash.
// Depends on oos_pkg and the stash core RTL; needs no other files.
module tb_top;
  import oos_pkg::*;

  localparam int unsigned DEPTH       = STASH_DEPTH_DEF;
  localparam int unsigned SCAN_CYCLES = STASH_DEPTH_DEF + 3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_REQS  = 235;

  typedef struct packed {
    oos_func_e   func;
    logic [31:0] block_id;
    logic [31:0] new_leaf;
    logic [63:0] data_in;
    logic        dummy_blk;
  } stash_req_t;

  typedef struct packed {
    logic [63:0] rd_word;
    oos_flags_t  flags;
  } stash_res_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_BITS-1:0]  s_axis_tuser  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [OUT_TUSER_BITS-1:0] m_axis_tuser;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_BITS-1:0]       cfg_data_i    = '0;

  // Random idling on both sides, and a hard stall of the result side
  logic idle_en    = 1'b1;
  logic sink_block = 1'b0;

  // Shadow copy of the stash contents and the dummy id
  logic [31:0] shadow_id   [DEPTH];
  logic [31:0] shadow_leaf [DEPTH];
  logic [63:0] shadow_data [DEPTH];
  logic [31:0] shadow_dummy;

  stash_res_t  pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  oblivious_oram_stash_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side ready: random stalls unless held off by a test
  always @(posedge clk_i) begin
    m_axis_tready <= !sink_block && !(idle_en && ($urandom_range(99) < 6));
  end

  // Full scan of the shadow stash for one request; updates the shadow state
  function automatic stash_res_t scan_stash(stash_req_t rq);
    stash_res_t res;
    res = '0;
    if (rq.func == FN_INSERT) begin
      if (!rq.dummy_blk) begin
        // first empty slot takes the block
        for (int i = 0; i < DEPTH; i++) begin
          if (!res.flags.inserted && shadow_id[i] == shadow_dummy) begin
            shadow_id[i]       = rq.block_id;
            shadow_leaf[i]     = rq.new_leaf;
            shadow_data[i]     = rq.data_in;
            res.flags.inserted = 1'b1;
          end
        end
        res.flags.overflow = !res.flags.inserted;
      end
    end else begin
      // every matching slot is relabeled; the last match wins on a read
      for (int i = 0; i < DEPTH; i++) begin
        if (shadow_id[i] == rq.block_id) begin
          res.flags.hit  = 1'b1;
          shadow_leaf[i] = rq.new_leaf;
          if (rq.func == FN_WRITE) shadow_data[i] = rq.data_in;
          if (rq.func == FN_READ) res.rd_word = shadow_data[i];
        end
      end
    end
    return res;
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] exp_val,
                                        logic [63:0] act_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected %h, got %h", $realtime, what, exp_val, act_val);
  endfunction

  // Result checker
  always @(posedge clk_i) begin : check_results
    stash_res_t want;
    oos_flags_t got_flags;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_flags = oos_flags_t'(m_axis_tuser);
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.rd_word)
          flag_mismatch("rd_word", want.rd_word, m_axis_tdata);
        if (got_flags.hit !== want.flags.hit)
          flag_mismatch("hit", 64'(want.flags.hit), 64'(got_flags.hit));
        if (got_flags.inserted !== want.flags.inserted)
          flag_mismatch("inserted", 64'(want.flags.inserted), 64'(got_flags.inserted));
        if (got_flags.overflow !== want.flags.overflow)
          flag_mismatch("overflow", 64'(want.flags.overflow), 64'(got_flags.overflow));
      end
    end
  end

  // Offer one request; returns at the edge where it is accepted, valid left high
  task automatic send_request(input oos_func_e func, input logic [31:0] block_id,
                              input logic [31:0] new_leaf, input logic [63:0] data_in,
                              input logic dummy_blk);
    stash_req_t rq;
    rq = '{func, block_id, new_leaf, data_in, dummy_blk};
    while (idle_en && ($urandom_range(99) < 6)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data_in, new_leaf, block_id};
    s_axis_tuser  <= {dummy_blk, func};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(scan_stash(rq));
  endtask

  // Stop offering, wait for every result, then let the core settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SCAN_CYCLES + 2) @(posedge clk_i);
  endtask

  task automatic write_dummy_id(input logic [31:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    shadow_dummy  = value;
  endtask

  // Field extremes, every request kind, duplicates and dummy-id corner cases
  task automatic test_directed();
    send_request(FN_READ, 32'h0, 32'h0, '0, 1'b0);              // miss on empty stash
    send_request(FN_READ, 32'hFFFF_FFFF, 32'h0, '1, 1'b1);      // empty slots match dummy
    send_request(FN_INSERT, 32'h0, 32'hFFFF_FFFF, '1, 1'b0);
    send_request(FN_INSERT, 32'h0, 32'h0, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_request(FN_READ, 32'h0, 32'h1111_2222, '0, 1'b0);      // two matches
    send_request(FN_WRITE, 32'h0, 32'hFFFF_FFFF, 64'hA5A5_5A5A_F00F_0FF0, 1'b1);
    send_request(FN_READ, 32'h0, 32'h0, '1, 1'b0);
    send_request(FN_RELABEL, 32'h0, 32'h1234_5678, '1, 1'b0);
    send_request(FN_READ, 32'h0, 32'h0, '0, 1'b1);
    send_request(FN_INSERT, 32'h5, 32'h7, '1, 1'b1);            // ignored block
    send_request(FN_READ, 32'h5, 32'h0, '0, 1'b0);
    send_request(FN_INSERT, 32'hFFFF_FFFF, 32'h99, 64'h77, 1'b0); // slot stays empty
    send_request(FN_INSERT, 32'h7, 32'h8, 64'h8000_0000_0000_0001, 1'b0);
    send_request(FN_WRITE, 32'hFFFF_FFFF, 32'hCAFE, 64'hDEAD_BEEF_0000_FFFF, 1'b0);
    send_request(FN_READ, 32'hFFFF_FFFF, 32'h0, '0, 1'b0);
    send_request(FN_READ, 32'h8000_0000, 32'h0, '0, 1'b0);
    send_request(FN_RELABEL, 32'h8000_0000, 32'h1, '0, 1'b0);
    send_request(FN_READ, 32'h7, 32'h0, '0, 1'b1);
  endtask

  // Dummy id moved onto live blocks: those slots become free, old empties do not
  task automatic test_dummy_id_change();
    write_dummy_id(32'h0);
    send_request(FN_INSERT, 32'hFFFF_FFFF, 32'h3, 64'h3, 1'b0);
    send_request(FN_READ, 32'hFFFF_FFFF, 32'h0, '0, 1'b0);
    send_request(FN_READ, 32'h0, 32'h0, '0, 1'b0);
    write_dummy_id(32'hFFFF_FFFF);
    send_request(FN_READ, 32'h0, 32'h4, '0, 1'b0);
  endtask

  // Fill every free slot, then overflow; no idling in this stretch
  task automatic test_stash_full();
    int free_slots;
    idle_en <= 1'b0;
    do begin
      free_slots = 0;
      foreach (shadow_id[i]) if (shadow_id[i] == shadow_dummy) free_slots++;
      if (free_slots > 0)
        send_request(FN_INSERT, $urandom, $urandom, {$urandom, $urandom}, 1'b0);
    end while (free_slots > 0);
    repeat (3) send_request(FN_INSERT, $urandom, $urandom, {$urandom, $urandom}, 1'b0);
    send_request(FN_INSERT, $urandom, $urandom, {$urandom, $urandom}, 1'b1);
    send_request(FN_READ, shadow_id[DEPTH-1], $urandom, '0, 1'b0);
    send_request(FN_WRITE, shadow_id[10], $urandom, {$urandom, $urandom}, 1'b0);
    send_request(FN_READ, shadow_id[10], $urandom, '0, 1'b0);
    idle_en <= 1'b1;
  endtask

  // Result side blocked long enough that the core must hold a request back
  task automatic test_backpressure();
    logic [31:0] id;
    id = $urandom;
    fork
      begin
        sink_block <= 1'b1;
        repeat (4 * SCAN_CYCLES) @(posedge clk_i);
        sink_block <= 1'b0;
      end
      begin
        send_request(FN_WRITE, id, $urandom, {$urandom, $urandom}, 1'b0);
        send_request(FN_READ, id, $urandom, '0, 1'b0);
        send_request(FN_RELABEL, id, $urandom, '0, 1'b1);
        send_request(FN_READ, $urandom, $urandom, '0, 1'b0);
      end
    join
    drain_results();
  endtask

  // Phases of random requests on a small id pool, the dummy id changing in between
  task automatic test_random_traffic();
    logic [31:0] pool [6];
    logic [31:0] next_dummy;
    logic [31:0] id;
    oos_func_e   func;
    logic        dmy;
    int          best_cnt, cnt, roll;
    for (int phase = 0; phase < PHASES; phase++) begin
      // extremes on odd phases; otherwise the most common id, which frees slots
      case (phase % 4)
        1: next_dummy = 32'h0;
        3: next_dummy = 32'hFFFF_FFFF;
        default: begin
          best_cnt   = 0;
          next_dummy = shadow_dummy;
          foreach (shadow_id[i]) begin
            cnt = 0;
            foreach (shadow_id[j]) if (shadow_id[j] == shadow_id[i]) cnt++;
            if (cnt > best_cnt && shadow_id[i] != shadow_dummy) begin
              best_cnt   = cnt;
              next_dummy = shadow_id[i];
            end
          end
        end
      endcase
      write_dummy_id(next_dummy);
      foreach (pool[k]) pool[k] = (k < 3) ? shadow_id[$urandom_range(DEPTH-1)] : $urandom;

      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2) drain_results();
        roll = $urandom_range(9);
        id   = (roll < 8) ? pool[$urandom_range(5)] : (roll == 8) ? shadow_dummy : $urandom;
        dmy  = ($urandom_range(9) == 0);
        roll = $urandom_range(99);
        if (roll < 25)      func = FN_INSERT;
        else if (roll < 50) func = FN_READ;
        else if (roll < 72) func = FN_WRITE;
        else if (roll < 90) func = FN_RELABEL;
        else begin
          // noise: any kind, any id, any dummy flag
          func = oos_func_e'($urandom_range(3));
          id   = $urandom;
          dmy  = 1'($urandom_range(1));
        end
        send_request(func, id, $urandom, {$urandom, $urandom}, dmy);
      end
    end
  endtask

  initial begin
    shadow_dummy = 32'hFFFF_FFFF;
    foreach (shadow_id[i]) begin
      shadow_id[i]   = shadow_dummy;
      shadow_leaf[i] = '0;
      shadow_data[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_dummy_id_change();
    test_stash_full();
    test_backpressure();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/oos_pkg.sv
rtl/core/oos_mem.sv
rtl/core/oos_ctrl.sv
rtl/core/oblivious_oram_stash_core.sv
verif/tb_top.sv
